// ----- rtl/core/sobel_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_pkg
// Shared constants for the RGB Sobel magnitude block.
// ----------------------------------------------------------------------------
package sobel_pkg;
	localparam int MAX_WIDTH_DEF    = 4096;
	localparam int CHANNEL_BITS_DEF = 8;
	localparam int NUM_CH           = 3;
	localparam int ROW_W            = 16;
	localparam int COL_W            = 12;
	localparam int MAG_W            = 11;
	localparam int WIDTH_REG_W      = 13;
	localparam int CFG_W            = 16;
	localparam logic CFG_IDX_WIDTH  = 1'b0;
	localparam logic CFG_IDX_HEIGHT = 1'b1;
	localparam logic [12:0] WIDTH_RESET  = 13'd640;
	localparam logic [15:0] HEIGHT_RESET = 16'd480;
endpackage

// ----- rtl/core/sobel_edge_magnitude_rgb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb
// Sobel 3x3 gradient magnitude per RGB channel on a raster pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid/in_ready) carries one raster pixel per transfer.
//  - Output channel (out_valid/out_ready) carries results: each pixel yields
//    up to two, the interior pixel above-left (window complete) first and
//    then a zero result if the pixel itself lies on the image border.
//  - Three channel lanes run side by side; a merge stage packs their
//    magnitudes with the row/column tags into one result.
//  - One pixel is processed at a time: a pixel occupies the block from its
//    transfer until its last result is loaded into the output register.
//    Line-store read, window shift, gradient, square and sum stages plus the
//    RW-stage square root (one bit per stage) lie between the pixel transfer
//    and its interior result; a border-only result skips the lane pipeline.
//  - Reset: counters go to zero, width 640, height 480. Line stores are not
//    cleared; their stale contents never reach a result.
//  - Receiver stall: results wait in the output register, nothing is lost.
//  - A configuration write restarts the frame at row 0, column 0.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb #(
	parameter int MAX_WIDTH    = sobel_pkg::MAX_WIDTH_DEF,
	parameter int CHANNEL_BITS = sobel_pkg::CHANNEL_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_index,
	input  logic [sobel_pkg::CFG_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [CHANNEL_BITS-1:0]    red_in,
	input  logic [CHANNEL_BITS-1:0]    green_in,
	input  logic [CHANNEL_BITS-1:0]    blue_in,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [sobel_pkg::ROW_W-1:0] out_row,
	output logic [sobel_pkg::COL_W-1:0] out_col,
	output logic [sobel_pkg::MAG_W-1:0] red_mag,
	output logic [sobel_pkg::MAG_W-1:0] green_mag,
	output logic [sobel_pkg::MAG_W-1:0] blue_mag,
	output logic                       frame_last
);
	localparam int CB   = CHANNEL_BITS;
	localparam int PW   = 3 * CB;
	localparam int AW   = $clog2(MAX_WIDTH);
	localparam int RW   = CB + 3;
	localparam int LAT  = RW + 3;          // window ready -> lane output
	localparam int ROWW = sobel_pkg::ROW_W;
	localparam int COLW = sobel_pkg::COL_W;
	localparam int MAGW = sobel_pkg::MAG_W;
	localparam int WRW  = sobel_pkg::WIDTH_REG_W;

	localparam logic [2:0] ST_IDLE = 3'd0, ST_READ = 3'd1, ST_WAIT = 3'd2,
		ST_INT = 3'd3, ST_BRD = 3'd4;

	logic [WRW-1:0]  width_q;
	logic [ROWW-1:0] height_q;
	logic [ROWW-1:0] row_q;
	logic [COLW+1:0] col_q;
	logic [2:0]      state_q;
	logic [$clog2(LAT+1)-1:0] cnt_q;
	logic [PW-1:0]   px_q;
	logic [PW-1:0]   upper_mem [MAX_WIDTH];
	logic [PW-1:0]   lower_mem [MAX_WIDTH];
	logic [PW-1:0]   up_rd_q, lo_rd_q;
	logic [PW-1:0]   win_q [9];
	logic            has_int_q, has_brd_q, last_q;
	logic [ROWW-1:0] prow_q;
	logic [COLW-1:0] pcol_q;

	// effective geometry
	logic [COLW+1:0] w_eff;
	logic [ROWW-1:0] h_eff;
	always_comb begin
		if (width_q == '0) w_eff = (COLW+2)'(1);
		else if (32'(width_q) > MAX_WIDTH) w_eff = (COLW+2)'(MAX_WIDTH);
		else w_eff = (COLW+2)'(width_q);
		h_eff = (height_q == '0) ? ROWW'(1) : height_q;
	end

	logic [AW-1:0] idx;
	assign idx = (32'(col_q) < MAX_WIDTH) ? AW'(col_q) : AW'(MAX_WIDTH - 1);

	logic acc_in, last_col, last_row;
	assign in_ready = (state_q == ST_IDLE);
	assign acc_in   = in_valid && in_ready;
	assign last_col = (col_q + 1'b1) >= w_eff;
	assign last_row = (17'(row_q) + 17'd1) >= 17'(h_eff);

	always_ff @(posedge clk) begin
		if (acc_in) begin
			px_q    <= {blue_in, green_in, red_in};
			up_rd_q <= upper_mem[idx];
			lo_rd_q <= lower_mem[idx];
			upper_mem[idx] <= lower_mem[idx];
			lower_mem[idx] <= {blue_in, green_in, red_in};
			has_int_q <= (row_q >= 2) && (col_q >= 2);
			has_brd_q <= (row_q == '0) || (col_q == '0) || last_col || last_row;
			last_q    <= last_col && last_row;
			prow_q    <= row_q;
			pcol_q    <= COLW'(col_q);
		end
		if (state_q == ST_READ) begin
			for (int r = 0; r < 3; r++) begin
				win_q[3*r]   <= win_q[3*r+1];
				win_q[3*r+1] <= win_q[3*r+2];
			end
			win_q[2] <= up_rd_q;
			win_q[5] <= lo_rd_q;
			win_q[8] <= px_q;
		end
	end

	// lanes: one per color
	logic [RW-1:0] lmag [3];
	for (genvar c = 0; c < 3; c++) begin : g_lane
		logic [9*CB-1:0] w;
		for (genvar i = 0; i < 9; i++) begin : g_tap
			assign w[i*CB +: CB] = win_q[i][c*CB +: CB];
		end
		sobel_lane #(.CB(CB), .RW(RW)) u_lane (.clk(clk), .win(w), .mag(lmag[c]));
	end

	// output register loads when a result is due and the slot is free
	logic load_out;
	assign load_out = (state_q == ST_INT || state_q == ST_BRD) && (!out_valid || out_ready);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sobel_pkg::WIDTH_RESET;
			height_q <= sobel_pkg::HEIGHT_RESET;
			row_q    <= '0;
			col_q    <= '0;
			state_q  <= ST_IDLE;
			cnt_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			if (load_out) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == sobel_pkg::CFG_IDX_WIDTH) width_q <= WRW'(cfg_data);
				else height_q <= cfg_data;
				row_q <= '0;
				col_q <= '0;
			end else if (acc_in) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + 1'b1;
				end else col_q <= col_q + 1'b1;
			end
			unique case (state_q)
				ST_IDLE: if (acc_in) state_q <= ST_READ;
				ST_READ: begin
					cnt_q   <= '0;
					state_q <= has_int_q ? ST_WAIT : (has_brd_q ? ST_BRD : ST_IDLE);
				end
				ST_WAIT: begin
					cnt_q <= cnt_q + 1'b1;
					if (32'(cnt_q) == LAT - 1) state_q <= ST_INT;
				end
				ST_INT: if (!out_valid || out_ready) begin
					state_q <= has_brd_q ? ST_BRD : ST_IDLE;
				end
				ST_BRD: if (!out_valid || out_ready) begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// merge stage: output register
	always_ff @(posedge clk) begin
		if (load_out) begin
			if (state_q == ST_INT) begin
				out_row    <= prow_q - 1'b1;
				out_col    <= pcol_q - 1'b1;
				red_mag    <= MAGW'(lmag[0]);
				green_mag  <= MAGW'(lmag[1]);
				blue_mag   <= MAGW'(lmag[2]);
				frame_last <= 1'b0;
			end else begin
				out_row    <= prow_q;
				out_col    <= pcol_q;
				red_mag    <= '0;
				green_mag  <= '0;
				blue_mag   <= '0;
				frame_last <= last_q;
			end
		end
	end

	// checks
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !in_ready) else $error("input taken while busy");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_row) && $stable(out_col)))
		else $error("result changed under stall");
	a_last_border: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_last) |-> (red_mag == '0 && blue_mag == '0))
		else $error("frame end on interior result");
endmodule

// ----- rtl/core/sobel_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_lane
// One color channel: 3x3 gradient, squared sum, then a pipelined integer
// square root resolving one result bit per stage.
// ----------------------------------------------------------------------------
module sobel_lane #(
	parameter int CB = sobel_pkg::CHANNEL_BITS_DEF,
	parameter int RW = CB + 3,
	parameter int SW = 2 * RW + 1
) (
	input  logic             clk,
	input  logic [9*CB-1:0]  win,   // row-major, top-left at [CB-1:0]
	output logic [RW-1:0]    mag
);
	// stage 1: gradients
	logic [CB-1:0]        p [9];
	logic signed [RW:0]   gx_s1, gy_s1;
	// stage 2: squares
	logic [2*RW-1:0]      sqx_s2, sqy_s2;
	// root pipeline
	logic [SW-1:0]        rem [RW+1];
	logic [RW-1:0]        root [RW+1];

	always_comb begin
		for (int i = 0; i < 9; i++) p[i] = win[i*CB +: CB];
	end

	always_ff @(posedge clk) begin
		gx_s1 <= (RW+1)'(p[0]) + ((RW+1)'(p[3]) <<< 1) + (RW+1)'(p[6])
		       - (RW+1)'(p[2]) - ((RW+1)'(p[5]) <<< 1) - (RW+1)'(p[8]);
		gy_s1 <= (RW+1)'(p[0]) + ((RW+1)'(p[1]) <<< 1) + (RW+1)'(p[2])
		       - (RW+1)'(p[6]) - ((RW+1)'(p[7]) <<< 1) - (RW+1)'(p[8]);
	end

	logic [RW-1:0] ax, ay;
	assign ax = RW'(gx_s1[RW] ? -gx_s1 : gx_s1);
	assign ay = RW'(gy_s1[RW] ? -gy_s1 : gy_s1);

	always_ff @(posedge clk) begin
		sqx_s2 <= ax * ax;
		sqy_s2 <= ay * ay;
	end

	always_ff @(posedge clk) begin
		rem[0]  <= SW'(sqx_s2) + SW'(sqy_s2);
		root[0] <= '0;
	end

	// restoring root, MSB first; stage k decides bit RW-1-k
	for (genvar k = 0; k < RW; k++) begin : g_root
		localparam int B = RW - 1 - k;
		logic [RW-1:0]   trial;
		logic [2*RW:0]   tsq;
		assign trial = root[k] | (RW'(1) << B);
		assign tsq   = (2*RW+1)'(trial) * (2*RW+1)'(trial);
		always_ff @(posedge clk) begin
			rem[k+1]  <= rem[k];
			root[k+1] <= (tsq <= (2*RW+1)'(rem[k])) ? trial : root[k];
		end
	end

	assign mag = root[RW];
endmodule
